### rtl/vnmf_pkg.sv
// Package for the voxel neighbourhood max and fill test block.
// Field widths, scan state type, control structs and register indexes.
// No dependencies.
`default_nettype none
package vnmf_pkg;

    // Default edge length of the voxel store
    localparam int MAX_DIM_DEF = 32;

    // Coordinate, dimension/counter, voxel and result widths
    localparam int CW = 5;
    localparam int DW = 6;
    localparam int VW = 16;
    localparam int MW = 15;

    // Function codes carried on tuser
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_DEPTH  = 2'd2
    } t_cfg_idx;

    // Scan sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_scan_state;

    // Sequencer to accumulator control
    typedef struct packed {
        logic clear;
        logic rd;
    } t_acc_ctl;

    // Accumulated result
    typedef struct packed {
        logic [MW-1:0] max;
        logic          filled;
    } t_result;

endpackage
`default_nettype wire

### rtl/vnmf_store.sv
// Single-port voxel store with registered read data.
// Depends on vnmf_pkg for the voxel width.
`default_nettype none
module vnmf_store #(
    parameter int ADDR_W = 15
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic                      i_we,
    input  wire logic [ADDR_W-1:0]         i_addr,
    input  wire logic [vnmf_pkg::VW-1:0]   i_wdata,
    output logic      [vnmf_pkg::VW-1:0]   o_rdata
);
    import vnmf_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [VW-1:0] mem [DEPTH];
    logic [VW-1:0] r_rdata;

    // one access a cycle: write, or read into the output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/vnmf_scan.sv
// Neighbourhood scan sequencer: clips the 3x3x3 window to the volume and
// walks it one store read per cycle, skipping the centre.
// Depends on vnmf_pkg.
`default_nettype none
module vnmf_scan #(
    parameter int MAX_DIM = vnmf_pkg::MAX_DIM_DEF,
    parameter int AW      = $clog2(MAX_DIM)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [vnmf_pkg::CW-1:0] i_x,
    input  wire logic [vnmf_pkg::CW-1:0] i_y,
    input  wire logic [vnmf_pkg::CW-1:0] i_z,
    input  wire logic [vnmf_pkg::DW-1:0] i_w,
    input  wire logic [vnmf_pkg::DW-1:0] i_h,
    input  wire logic [vnmf_pkg::DW-1:0] i_d,
    input  wire logic                    i_res_rdy,
    output logic                         o_idle,
    output logic                         o_done,
    output vnmf_pkg::t_acc_ctl           o_ctl,
    output logic [3*AW-1:0]              o_addr
);
    import vnmf_pkg::*;

    t_scan_state r_state, n_state;

    logic [DW-1:0] r_i, r_j, r_k;
    logic [DW-1:0] r_x0, r_y0, r_xn, r_yn, r_zn;
    logic [DW-1:0] r_cx, r_cy, r_cz;

    logic [DW-1:0] dim_w, dim_h, dim_d;
    logic [DW-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    logic [DW-1:0] ex, ey, ez;
    logic          empty, i_wrap, j_wrap, k_wrap, last, centre;

    // clamp dimensions to the store edge
    always_comb begin
        dim_w = (int'(i_w) > MAX_DIM) ? DW'(MAX_DIM) : i_w;
        dim_h = (int'(i_h) > MAX_DIM) ? DW'(MAX_DIM) : i_h;
        dim_d = (int'(i_d) > MAX_DIM) ? DW'(MAX_DIM) : i_d;
    end

    // window bounds: lo = c-1 floored at 0, hi = min(c+2, dim), exclusive
    always_comb begin
        lo_x = (i_x == '0) ? '0 : {1'b0, i_x} - DW'(1);
        lo_y = (i_y == '0) ? '0 : {1'b0, i_y} - DW'(1);
        lo_z = (i_z == '0) ? '0 : {1'b0, i_z} - DW'(1);
        ex   = {1'b0, i_x} + DW'(2);
        ey   = {1'b0, i_y} + DW'(2);
        ez   = {1'b0, i_z} + DW'(2);
        hi_x = (ex < dim_w) ? ex : dim_w;
        hi_y = (ey < dim_h) ? ey : dim_h;
        hi_z = (ez < dim_d) ? ez : dim_d;
        empty = (lo_x >= hi_x) || (lo_y >= hi_y) || (lo_z >= hi_z);
    end

    // walk position flags
    always_comb begin
        i_wrap = (r_i + DW'(1)) == r_xn;
        j_wrap = (r_j + DW'(1)) == r_yn;
        k_wrap = (r_k + DW'(1)) == r_zn;
        last   = i_wrap && j_wrap && k_wrap;
        centre = (r_i == r_cx) && (r_j == r_cy) && (r_k == r_cz);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = empty ? S_DONE : S_RUN;
            S_RUN:   if (last) n_state = S_DRAIN;
            S_DRAIN: n_state = S_DONE;
            S_DONE:  if (i_res_rdy) n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_idle    = (r_state == S_IDLE);
        o_done    = (r_state == S_DONE);
        o_ctl.clear = (r_state == S_IDLE) && i_start;
        o_ctl.rd    = (r_state == S_RUN) && !centre;
    end

    assign o_addr = {AW'(r_k), AW'(r_j), AW'(r_i)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // window registers and walk counters, x fastest
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_x0 <= lo_x;
            r_y0 <= lo_y;
            r_xn <= hi_x;
            r_yn <= hi_y;
            r_zn <= hi_z;
            r_i  <= lo_x;
            r_j  <= lo_y;
            r_k  <= lo_z;
            r_cx <= {1'b0, i_x};
            r_cy <= {1'b0, i_y};
            r_cz <= {1'b0, i_z};
        end else if (r_state == S_RUN) begin
            if (!i_wrap) begin
                r_i <= r_i + DW'(1);
            end else begin
                r_i <= r_x0;
                if (!j_wrap) begin
                    r_j <= r_j + DW'(1);
                end else begin
                    r_j <= r_y0;
                    r_k <= r_k + DW'(1);
                end
            end
        end
    end

`ifndef ASSERT_OFF
    // walk stays inside the clipped window
    a_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_i < r_xn && r_j < r_yn && r_k < r_zn
                                && r_i >= r_x0 && r_j >= r_y0))
        else $error("scan position left the window");
    // the centre voxel is never read
    a_no_centre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.rd |-> !(r_i == r_cx && r_j == r_cy && r_k == r_cz))
        else $error("centre voxel read");
    // no read issued outside the walk
    a_rd_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RUN) |-> !o_ctl.rd)
        else $error("read issued outside the walk");
    // the walk always ends through the drain cycle
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && last) |=> (r_state == S_DRAIN))
        else $error("walk did not drain");
`endif

endmodule
`default_nettype wire

### rtl/vnmf_acc.sv
// Running maximum (floor zero) and all-nonzero flag over store read data.
// Depends on vnmf_pkg.
`default_nettype none
module vnmf_acc (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire vnmf_pkg::t_acc_ctl    i_ctl,
    input  wire logic [vnmf_pkg::VW-1:0] i_rdata,
    output vnmf_pkg::t_result          o_res
);
    import vnmf_pkg::*;

    logic          r_tag;
    logic [MW-1:0] r_max;
    logic          r_filled;

    // read data is valid the cycle after the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= 1'b0;
        end else begin
            r_tag <= i_ctl.rd;
        end
    end

    // only non-negative words can beat the floor
    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_max    <= '0;
            r_filled <= 1'b1;
        end else if (r_tag) begin
            if (!i_rdata[VW-1] && (i_rdata[MW-1:0] > r_max)) begin
                r_max <= i_rdata[MW-1:0];
            end
            if (i_rdata == '0) begin
                r_filled <= 1'b0;
            end
        end
    end

    assign o_res.max    = r_max;
    assign o_res.filled = r_filled;

endmodule
`default_nettype wire

### rtl/voxel_neighbourhood_max_and_fill_test.sv
// Query: accepted while the scan is idle, then a walk over the clipped window (up to 27 slots, centre
// slot included but not read), a drain state and a result state; the single store port gives one read
// per cycle. Empty window: straight to the result state. No word is accepted until the scan is idle.
// Write words: one per cycle while the scan is idle, written into the store at the accepting edge.
// Output word sits in a register, so the next word is accepted while a result waits.
// Reset is synchronous: clears control and sets the dimensions to 32; store not cleared.
`default_nettype none
module voxel_neighbourhood_max_and_fill_test #(
    parameter int MAX_DIM = vnmf_pkg::MAX_DIM_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [vnmf_pkg::DW-1:0] i_cfg_wdata,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: voxel_x[4:0], voxel_y[9:5], voxel_z[14:10], voxel_value[30:15], zero[31]
    input  wire logic [31:0] s_axis_tdata,
    // tuser: func[0]
    input  wire logic        s_axis_tuser,
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: neighbour_max[14:0], all_neighbours_nonzero[15]
    output logic [15:0]      m_axis_tdata
);
    import vnmf_pkg::*;

    localparam int AW = $clog2(MAX_DIM);

    logic [DW-1:0] r_vol_w, r_vol_h, r_vol_d;

    logic [CW-1:0] in_x, in_y, in_z;
    logic [VW-1:0] in_value;
    logic          in_acc, wr_en, q_start;

    logic          scan_idle, scan_done, res_rdy;
    t_acc_ctl      acc_ctl;
    t_result       res;
    logic [3*AW-1:0] scan_addr, st_addr;
    logic [VW-1:0] st_rdata;

    logic          r_m_vld;
    logic [15:0]   r_m_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol_w <= DW'(32);
            r_vol_h <= DW'(32);
            r_vol_d <= DW'(32);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:  r_vol_w <= i_cfg_wdata;
                CFG_HEIGHT: r_vol_h <= i_cfg_wdata;
                CFG_DEPTH:  r_vol_d <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input word unpack and dispatch
    always_comb begin
        in_x     = s_axis_tdata[4:0];
        in_y     = s_axis_tdata[9:5];
        in_z     = s_axis_tdata[14:10];
        in_value = s_axis_tdata[30:15];
        s_axis_tready = scan_idle;
        in_acc   = s_axis_tvalid && scan_idle;
        wr_en    = in_acc && (s_axis_tuser == FUNC_WRITE) && (int'(in_x) < MAX_DIM)
                   && (int'(in_y) < MAX_DIM) && (int'(in_z) < MAX_DIM);
        q_start  = in_acc && (s_axis_tuser == FUNC_QUERY);
    end

    // store port: writes only while the scan is idle
    assign st_addr = scan_idle ? {AW'(in_z), AW'(in_y), AW'(in_x)} : scan_addr;

    vnmf_store #(
        .ADDR_W (3*AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (wr_en || acc_ctl.rd),
        .i_we    (wr_en),
        .i_addr  (st_addr),
        .i_wdata (in_value),
        .o_rdata (st_rdata)
    );

    vnmf_scan #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (q_start),
        .i_x       (in_x),
        .i_y       (in_y),
        .i_z       (in_z),
        .i_w       (r_vol_w),
        .i_h       (r_vol_h),
        .i_d       (r_vol_d),
        .i_res_rdy (res_rdy),
        .o_idle    (scan_idle),
        .o_done    (scan_done),
        .o_ctl     (acc_ctl),
        .o_addr    (scan_addr)
    );

    vnmf_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (acc_ctl),
        .i_rdata (st_rdata),
        .o_res   (res)
    );

    // output register: loads when empty or being emptied
    assign res_rdy = !r_m_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (scan_done && res_rdy) begin
            r_m_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_done && res_rdy) begin
            r_m_data <= {res.filled, res.max};
        end
    end

    assign m_axis_tvalid = r_m_vld;
    assign m_axis_tdata  = r_m_data;

endmodule
`default_nettype wire

### test/voxel_neighbourhood_max_and_fill_test_test.sv
// Self-checking bench for the voxel neighbourhood max and fill test block.
// Drives voxel writes and neighbourhood queries on the input stream, predicts each query
// result and checks it on the output stream. Depends on vnmf_pkg and the block's RTL.
`default_nettype none
module voxel_neighbourhood_max_and_fill_test_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vnmf_pkg::*;

    localparam int EDGE = MAX_DIM_DEF;
    localparam int STORE_DEPTH = EDGE * EDGE * EDGE;

    // One input word and one result word, as fields
    typedef struct {
        logic            func;
        logic [CW-1:0]   x;
        logic [CW-1:0]   y;
        logic [CW-1:0]   z;
        logic [VW-1:0]   value;
    } t_voxel_word;

    typedef struct {
        logic [MW-1:0]   peak;
        logic            filled;
    } t_fill_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [1:0]        i_cfg_idx = 2'd0;
    logic [DW-1:0]     i_cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;
    logic              s_axis_tuser = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;

    // Bench copy of the volume and its dimensions
    logic signed [VW-1:0] voxel_mem [0:STORE_DEPTH-1];
    bit                   written_map [0:STORE_DEPTH-1];
    int                   dim_w = EDGE;
    int                   dim_h = EDGE;
    int                   dim_d = EDGE;

    t_voxel_word  voxel_words[$];
    t_fill_result results_due[$];
    t_voxel_word  in_flight;
    int           words_queued = 0;
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           fill_zero_pct = 15;
    bit           fill_negative = 1'b0;

    voxel_neighbourhood_max_and_fill_test u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest correct run
    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Idles at random with a 20 percent chance, except in a recurring calm stretch without idles
    function automatic bit idle_now();
        if ((cycle_count % 8000) >= 3000 && (cycle_count % 8000) < 5000) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 20;
    endfunction

    function automatic int store_addr(input int x, input int y, input int z);
        return (z * EDGE + y) * EDGE + x;
    endfunction

    // Window bounds along one axis, clipped to the volume (upper bound exclusive)
    function automatic int lo_edge(input int c);
        return (c == 0) ? 0 : c - 1;
    endfunction

    function automatic int hi_edge(input int c, input int dim);
        int span;
        span = (dim > EDGE) ? EDGE : dim;
        return (c + 2 < span) ? c + 2 : span;
    endfunction

    // Largest neighbour (floor zero) and whether no neighbour holds zero
    function automatic t_fill_result scan_neighbours(input int cx, input int cy, input int cz);
        t_fill_result res;
        int best;
        int sample;
        best = 0;
        res.filled = 1'b1;
        for (int k = lo_edge(cz); k < hi_edge(cz, dim_d); k++) begin
            for (int j = lo_edge(cy); j < hi_edge(cy, dim_h); j++) begin
                for (int i = lo_edge(cx); i < hi_edge(cx, dim_w); i++) begin
                    if (!(i == cx && j == cy && k == cz)) begin
                        sample = voxel_mem[store_addr(i, j, k)];
                        if (sample > best) begin
                            best = sample;
                        end
                        if (sample == 0) begin
                            res.filled = 1'b0;
                        end
                    end
                end
            end
        end
        res.peak = best[MW-1:0];
        return res;
    endfunction

    function automatic logic [VW-1:0] rand_value();
        int r;
        r = $urandom_range(0, 99);
        if (fill_negative) begin
            return {1'b1, 15'($urandom)};
        end
        if (r < fill_zero_pct) begin
            return '0;
        end
        if (r < fill_zero_pct + 8) begin
            case ($urandom_range(0, 3))
                0: return 16'h7fff;
                1: return 16'h8000;
                2: return 16'hffff;
                default: return 16'h0001;
            endcase
        end
        return 16'($urandom);
    endfunction

    // Coordinates kept to a few bands so that the written part of the store stays small;
    // the bands reach past the border, so centres outside the volume come up too
    function automatic int rand_coord(input int dim);
        int span;
        int base;
        span = (dim > EDGE) ? EDGE : dim;
        if (span <= 8) begin
            return $urandom_range(0, span + 1);
        end
        base = ($urandom_range(0, 1) == 0) ? 0 : span - 3;
        base = base + $urandom_range(0, 4);
        return (base > EDGE - 1) ? EDGE - 1 : base;
    endfunction

    task automatic push_write(input int x, input int y, input int z, input logic [VW-1:0] v);
        t_voxel_word w;
        w.func = FUNC_WRITE;
        w.x = x[CW-1:0];
        w.y = y[CW-1:0];
        w.z = z[CW-1:0];
        w.value = v;
        written_map[store_addr(x, y, z)] = 1'b1;
        voxel_words.push_back(w);
        words_queued++;
    endtask

    // A query is preceded by writes to every voxel of its window not yet written,
    // the centre included, so the block never reads an unwritten entry
    task automatic push_query(input int cx, input int cy, input int cz);
        t_voxel_word w;
        for (int k = lo_edge(cz); k < hi_edge(cz, dim_d); k++) begin
            for (int j = lo_edge(cy); j < hi_edge(cy, dim_h); j++) begin
                for (int i = lo_edge(cx); i < hi_edge(cx, dim_w); i++) begin
                    if (!written_map[store_addr(i, j, k)]) begin
                        push_write(i, j, k, rand_value());
                    end
                end
            end
        end
        if (!written_map[store_addr(cx, cy, cz)]) begin
            push_write(cx, cy, cz, rand_value());
        end
        w.func = FUNC_QUERY;
        w.x = cx[CW-1:0];
        w.y = cy[CW-1:0];
        w.z = cz[CW-1:0];
        w.value = 16'($urandom);
        voxel_words.push_back(w);
        words_queued++;
    endtask

    // Random mix: queries, overwrites inside the bands, and stray writes anywhere
    task automatic run_random(input int n_words, input int zero_pct);
        int start;
        int r;
        start = words_queued;
        fill_zero_pct = zero_pct;
        @(negedge i_clk);
        while (words_queued - start < n_words) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                push_query(rand_coord(dim_w), rand_coord(dim_h), rand_coord(dim_d));
            end else if (r < 90) begin
                push_write(rand_coord(dim_w), rand_coord(dim_h), rand_coord(dim_d),
                           rand_value());
            end else begin
                push_write($urandom_range(0, EDGE - 1), $urandom_range(0, EDGE - 1),
                           $urandom_range(0, EDGE - 1), 16'($urandom));
            end
        end
    endtask

    // Wait for every word to be taken and every result to come back, then let the
    // block finish any write still in hand
    task automatic settle();
        while (voxel_words.size() != 0 || s_axis_tvalid || results_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [DW-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_WIDTH:  dim_w = v;
            CFG_HEIGHT: dim_h = v;
            default:    dim_d = v;
        endcase
    endtask

    task automatic set_volume(input int w, input int h, input int d);
        cfg_write(CFG_WIDTH, w[DW-1:0]);
        cfg_write(CFG_HEIGHT, h[DW-1:0]);
        cfg_write(CFG_DEPTH, d[DW-1:0]);
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Driver: presents the next pending word when the slot is free, unless it idles at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (in_flight.func == FUNC_WRITE) begin
                    voxel_mem[store_addr(in_flight.x, in_flight.y, in_flight.z)] =
                        in_flight.value;
                end else begin
                    results_due.push_back(scan_neighbours(in_flight.x, in_flight.y,
                                                          in_flight.z));
                end
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (voxel_words.size() != 0 && !idle_now()) begin
                    in_flight = voxel_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {1'b0, in_flight.value, in_flight.z, in_flight.y,
                                     in_flight.x};
                    s_axis_tuser <= in_flight.func;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result word against the oldest prediction
    always @(posedge i_clk) begin
        t_fill_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result word %h", m_axis_tdata));
                end else begin
                    want = results_due.pop_front();
                    if (m_axis_tdata[MW-1:0] !== want.peak) begin
                        report_mismatch($sformatf("neighbour_max %0d, predicted %0d",
                                                  m_axis_tdata[MW-1:0], want.peak));
                    end
                    if (m_axis_tdata[MW] !== want.filled) begin
                        report_mismatch($sformatf("all_neighbours_nonzero %b, predicted %b",
                                                  m_axis_tdata[MW], want.filled));
                    end
                end
            end
            m_axis_tready <= !idle_now();
        end
    end

    // Stimulus: directed corners and extremes, then random phases over several volumes
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // full-size volume from reset; corner window of negatives gives max 0, flag set
        fill_zero_pct = 0;
        fill_negative = 1'b1;
        push_query(0, 0, 0);
        fill_negative = 1'b0;
        push_write(1, 1, 1, 16'h7fff);
        push_query(0, 0, 0);
        push_write(0, 1, 0, 16'h0000);
        push_write(0, 0, 1, 16'h8000);
        push_query(0, 0, 0);
        push_write(31, 31, 30, 16'hffff);
        push_query(31, 31, 31);
        push_query(31, 0, 31);
        push_query(0, 31, 15);
        run_random(100, 15);
        settle();

        // small box, writes beyond it still land in the store
        set_volume(4, 3, 5);
        run_random(110, 10);
        settle();

        // single voxel: no window holds a neighbour
        set_volume(1, 1, 1);
        run_random(60, 20);
        settle();

        // zero width: nothing is scanned
        set_volume(0, 8, 8);
        run_random(60, 20);
        settle();

        // oversized dimensions clamp to the store edge
        set_volume(63, 2, 40);
        run_random(110, 5);
        settle();

        set_volume(2, 32, 3);
        run_random(110, 30);
        settle();

        set_volume(20, 6, 33);
        run_random(110, 10);
        settle();

        set_volume(32, 32, 32);
        run_random(110, 2);
        settle();

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
